// File: rtl/core/vlps_pkg.sv
// ----------------------------------------------------------------------------
// vlps_pkg
// Shared constants, register indexes and helpers for the light pattern
// sequencer.
// ----------------------------------------------------------------------------
package vlps_pkg;

  // Payload field widths
  localparam int FRAME_ID_W  = 11;
  localparam int DLEN_W      = 4;
  localparam int CMD_BYTE_W  = 8;
  localparam int TIME_W      = 32;
  localparam int LED_IDX_W   = 5;
  localparam int COLOR_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int WDOG_W      = 16;
  localparam int TICK_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WDOG_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE_ON     = 3'd7;

  // Register reset values
  localparam logic [WDOG_W-1:0]  RST_WDOG_LIMIT    = 16'd500;
  localparam logic [COLOR_W-1:0] RST_HEAD_COLOR    = 32'h00FF_0000;
  localparam logic [TICK_W-1:0]  RST_STEP_TICKS    = 8'd2;
  localparam logic [TICK_W-1:0]  RST_HOLD_TICKS    = 8'd6;
  localparam logic [TICK_W-1:0]  RST_STROBE_PERIOD = 8'd66;
  localparam logic [TICK_W-1:0]  RST_STROBE_ON     = 8'd6;

  // Item opcodes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Command frame match
  localparam logic [FRAME_ID_W-1:0] CMD_FRAME_ID = 11'h660;

  // Command byte bit positions
  localparam int FLAG_HEADLIGHT = 0;
  localparam int FLAG_LEFT      = 1;
  localparam int FLAG_RIGHT     = 2;
  localparam int FLAG_BRAKE     = 4;
  localparam int FLAG_STROBE    = 5;
  localparam int FLAG_CUSTOM_LO = 6;
  localparam int FLAG_CUSTOM_HI = 7;

  // Packed W,R,G,B colors
  localparam logic [COLOR_W-1:0] COLOR_AMBER = 32'h00FF_6400;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 32'h00FF_0000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] COLOR_OFF   = 32'h0000_0000;

  // Default string geometry and queue depth
  localparam int NUM_LEDS_DEF      = 32;
  localparam int FIRST_LIT_LED_DEF = 1;
  localparam int QUEUE_DEPTH       = 2;

  // Number of animated LEDs
  function automatic int span_leds(input int num_leds, input int first_lit);
    return (num_leds > first_lit) ? (num_leds - first_lit) : 0;
  endfunction

  // Counter width able to hold 0..span
  function automatic int cnt_width(input int num_leds, input int first_lit);
    return $clog2(span_leds(num_leds, first_lit) + 2);
  endfunction

endpackage

// File: rtl/core/vlps_in_if.sv
// ----------------------------------------------------------------------------
// vlps_in_if
// Input item channel: valid/ready handshake with command and tick fields.
// ----------------------------------------------------------------------------
interface vlps_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [vlps_pkg::FRAME_ID_W-1:0]   frame_id;
  logic                              extended_id;
  logic [vlps_pkg::DLEN_W-1:0]       data_length;
  logic [vlps_pkg::CMD_BYTE_W-1:0]   command_byte;
  logic [vlps_pkg::TIME_W-1:0]       now_ms;

  modport source (
    output valid, opcode, frame_id, extended_id, data_length, command_byte, now_ms,
    input  ready
  );
  modport sink (
    input  valid, opcode, frame_id, extended_id, data_length, command_byte, now_ms,
    output ready
  );
endinterface

// File: rtl/core/vlps_out_if.sv
// ----------------------------------------------------------------------------
// vlps_out_if
// Result channel: one LED color per beat.
// ----------------------------------------------------------------------------
interface vlps_out_if;
  logic                              valid;
  logic                              ready;
  logic [vlps_pkg::LED_IDX_W-1:0]    led_index;
  logic [vlps_pkg::COLOR_W-1:0]      pixel_color;
  logic                              fault_code;
  logic                              last_led;

  modport source (
    output valid, led_index, pixel_color, fault_code, last_led,
    input  ready
  );
  modport sink (
    input  valid, led_index, pixel_color, fault_code, last_led,
    output ready
  );
endinterface

// File: rtl/core/vlps_fifo.sv
// ----------------------------------------------------------------------------
// vlps_fifo
// Small register queue carrying frame descriptors from front to back end.
// ----------------------------------------------------------------------------
module vlps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vlps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count_r <= count_r + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/vlps_front.sv
// ----------------------------------------------------------------------------
// vlps_front
// Accepts items, holds configuration and latched command, checks the
// watchdog, advances the selected animation and queues a frame descriptor.
// ----------------------------------------------------------------------------
module vlps_front #(
  parameter int NUM_LEDS      = vlps_pkg::NUM_LEDS_DEF,
  parameter int FIRST_LIT_LED = vlps_pkg::FIRST_LIT_LED_DEF,
  parameter int DESC_W        = 1 + vlps_pkg::COLOR_W
                                + 2 * vlps_pkg::cnt_width(NUM_LEDS, FIRST_LIT_LED)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  vlps_in_if.sink                          in_chan,
  input  logic                             cfg_we,
  input  logic [vlps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vlps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [DESC_W-1:0]                q_data
);

  localparam int SPAN  = vlps_pkg::span_leds(NUM_LEDS, FIRST_LIT_LED);
  localparam int CNT_W = vlps_pkg::cnt_width(NUM_LEDS, FIRST_LIT_LED);
  localparam int TW    = vlps_pkg::TICK_W;
  localparam logic [CNT_W-1:0] SPAN_C  = CNT_W'(SPAN);
  localparam logic [CNT_W:0]   SPAN_CX = (CNT_W + 1)'(SPAN);

  // Turn animation phases
  localparam logic [1:0] TURN_FILLING    = 2'd0;
  localparam logic [1:0] TURN_HOLD_FULL  = 2'd1;
  localparam logic [1:0] TURN_EMPTYING   = 2'd2;
  localparam logic [1:0] TURN_HOLD_EMPTY = 2'd3;

  // Brake animation phases
  localparam logic [1:0] BRAKE_IDLE     = 2'd0;
  localparam logic [1:0] BRAKE_FILLING  = 2'd1;
  localparam logic [1:0] BRAKE_HELD     = 2'd2;
  localparam logic [1:0] BRAKE_EMPTYING = 2'd3;

  // Configuration registers
  logic [vlps_pkg::WDOG_W-1:0]  wdog_limit_r;
  logic [vlps_pkg::COLOR_W-1:0] head_color_r;
  logic                         resp_left_r, resp_right_r;
  logic [TW-1:0]                step_ticks_r, hold_ticks_r;
  logic [TW-1:0]                strobe_period_r, strobe_on_r;

  // Command and animation state
  logic [vlps_pkg::CMD_BYTE_W-1:0] flags_r, flags_nxt;
  logic [vlps_pkg::TIME_W-1:0]     last_time_r, last_time_nxt;
  logic [1:0]       turn_phase_r, turn_phase_nxt;
  logic [CNT_W-1:0] turn_fill_r, turn_fill_nxt, turn_empty_r, turn_empty_nxt;
  logic [TW-1:0]    turn_tick_r, turn_tick_nxt;
  logic [1:0]       brake_phase_r, brake_phase_nxt;
  logic [CNT_W-1:0] brake_fill_r, brake_fill_nxt, brake_empty_r, brake_empty_nxt;
  logic [TW-1:0]    brake_tick_r, brake_tick_nxt;
  logic [TW-1:0]    strobe_tick_r, strobe_tick_nxt;

  // Datapath temporaries
  logic                            accept, is_tick, frame_match, wdog_fault;
  logic                            brake_on, turn_on;
  logic [vlps_pkg::TIME_W-1:0]     age;
  logic [TW-1:0]                   t_tick, b_tick, s_tick;
  logic                            t_step_hit, t_hold_hit, b_step_hit;
  logic [CNT_W:0]                  t_fill_inc, t_empty_inc, b_fill_inc, b_empty_inc;
  logic                            d_fault;
  logic [vlps_pkg::COLOR_W-1:0]    d_color;
  logic [CNT_W-1:0]                d_lo, d_hi;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_tick       = (in_chan.opcode == vlps_pkg::OP_TICK);
  assign frame_match   = !in_chan.extended_id
                         && (in_chan.frame_id == vlps_pkg::CMD_FRAME_ID)
                         && (in_chan.data_length != '0);

  // Watchdog age compare, modulo 2^32
  assign age        = in_chan.now_ms - last_time_r;
  assign wdog_fault = (age > {{(vlps_pkg::TIME_W - vlps_pkg::WDOG_W){1'b0}}, wdog_limit_r});

  assign brake_on = flags_r[vlps_pkg::FLAG_BRAKE];
  assign turn_on  = (resp_left_r && flags_r[vlps_pkg::FLAG_LEFT])
                    || (resp_right_r && flags_r[vlps_pkg::FLAG_RIGHT]);

  // Candidate counter steps
  assign t_tick      = turn_tick_r + 1'b1;
  assign b_tick      = brake_tick_r + 1'b1;
  assign t_step_hit  = (t_tick >= step_ticks_r);
  assign t_hold_hit  = (t_tick >= hold_ticks_r);
  assign b_step_hit  = (b_tick >= step_ticks_r);
  assign t_fill_inc  = {1'b0, turn_fill_r} + 1'b1;
  assign t_empty_inc = {1'b0, turn_empty_r} + 1'b1;
  assign b_fill_inc  = {1'b0, brake_fill_r} + 1'b1;
  assign b_empty_inc = {1'b0, brake_empty_r} + 1'b1;

  // Item handling and animation advance
  always_comb begin
    flags_nxt       = flags_r;
    last_time_nxt   = last_time_r;
    turn_phase_nxt  = turn_phase_r;
    turn_fill_nxt   = turn_fill_r;
    turn_empty_nxt  = turn_empty_r;
    turn_tick_nxt   = turn_tick_r;
    brake_phase_nxt = brake_phase_r;
    brake_fill_nxt  = brake_fill_r;
    brake_empty_nxt = brake_empty_r;
    brake_tick_nxt  = brake_tick_r;
    strobe_tick_nxt = strobe_tick_r;
    s_tick          = strobe_tick_r + 1'b1;
    d_fault         = 1'b0;
    d_color         = vlps_pkg::COLOR_OFF;
    d_lo            = '0;
    d_hi            = '0;

    if (accept && !is_tick) begin
      if (frame_match) begin
        flags_nxt     = in_chan.command_byte;
        last_time_nxt = in_chan.now_ms;
      end
    end else if (accept && is_tick) begin
      if (wdog_fault) begin
        d_fault = 1'b1;
      end else if (brake_on || (brake_phase_r != BRAKE_IDLE)) begin
        // Brake: fill while pressed, empty out after release
        brake_tick_nxt = b_tick;
        case (brake_phase_r)
          BRAKE_IDLE: begin
            if (brake_on) begin
              brake_phase_nxt = BRAKE_FILLING;
              brake_tick_nxt  = '0;
              brake_fill_nxt  = '0;
            end
          end
          BRAKE_FILLING: begin
            if (b_step_hit) begin
              brake_tick_nxt = '0;
              if (b_fill_inc >= SPAN_CX) begin
                brake_fill_nxt  = SPAN_C;
                brake_phase_nxt = BRAKE_HELD;
              end else begin
                brake_fill_nxt = b_fill_inc[CNT_W-1:0];
              end
            end
            if (!brake_on) begin
              brake_empty_nxt = SPAN_C - brake_fill_nxt;
              brake_phase_nxt = BRAKE_EMPTYING;
              brake_tick_nxt  = '0;
            end
          end
          BRAKE_HELD: begin
            if (!brake_on) begin
              brake_phase_nxt = BRAKE_EMPTYING;
              brake_tick_nxt  = '0;
              brake_empty_nxt = '0;
            end
          end
          default: begin
            if (b_step_hit) begin
              brake_tick_nxt = '0;
              if (b_empty_inc >= SPAN_CX) begin
                brake_phase_nxt = BRAKE_IDLE;
                brake_fill_nxt  = '0;
                brake_empty_nxt = '0;
              end else begin
                brake_empty_nxt = b_empty_inc[CNT_W-1:0];
              end
            end
            if (brake_on) begin
              brake_fill_nxt  = SPAN_C - brake_empty_nxt;
              brake_phase_nxt = BRAKE_FILLING;
              brake_tick_nxt  = '0;
            end
          end
        endcase
        d_color = vlps_pkg::COLOR_RED;
        case (brake_phase_nxt)
          BRAKE_FILLING:  d_hi = brake_fill_nxt;
          BRAKE_HELD:     d_hi = SPAN_C;
          BRAKE_EMPTYING: begin
            d_lo = brake_empty_nxt;
            d_hi = SPAN_C;
          end
          default:        d_color = vlps_pkg::COLOR_OFF;
        endcase
      end else if (turn_on) begin
        // Turn: fill, hold full, empty, hold empty
        turn_tick_nxt = t_tick;
        case (turn_phase_r)
          TURN_FILLING: begin
            if (t_step_hit) begin
              turn_tick_nxt = '0;
              if (t_fill_inc >= SPAN_CX) begin
                turn_fill_nxt  = SPAN_C;
                turn_phase_nxt = TURN_HOLD_FULL;
              end else begin
                turn_fill_nxt = t_fill_inc[CNT_W-1:0];
              end
            end
          end
          TURN_HOLD_FULL: begin
            if (t_hold_hit) begin
              turn_tick_nxt  = '0;
              turn_phase_nxt = TURN_EMPTYING;
            end
          end
          TURN_EMPTYING: begin
            if (t_step_hit) begin
              turn_tick_nxt = '0;
              if (t_empty_inc >= SPAN_CX) begin
                turn_empty_nxt = SPAN_C;
                turn_phase_nxt = TURN_HOLD_EMPTY;
              end else begin
                turn_empty_nxt = t_empty_inc[CNT_W-1:0];
              end
            end
          end
          default: begin
            if (t_hold_hit) begin
              turn_tick_nxt  = '0;
              turn_fill_nxt  = '0;
              turn_empty_nxt = '0;
              turn_phase_nxt = TURN_FILLING;
            end
          end
        endcase
        d_color = vlps_pkg::COLOR_AMBER;
        case (turn_phase_nxt)
          TURN_FILLING:   d_hi = turn_fill_nxt;
          TURN_HOLD_FULL: d_hi = SPAN_C;
          TURN_EMPTYING: begin
            d_lo = turn_empty_nxt;
            d_hi = SPAN_C;
          end
          default:        d_color = vlps_pkg::COLOR_OFF;
        endcase
      end else if (flags_r[vlps_pkg::FLAG_STROBE]) begin
        // Strobe: free-running period counter
        if (s_tick >= strobe_period_r) begin
          s_tick = '0;
        end
        strobe_tick_nxt = s_tick;
        d_hi    = SPAN_C;
        d_color = (s_tick < strobe_on_r) ? vlps_pkg::COLOR_WHITE : vlps_pkg::COLOR_OFF;
      end else if (flags_r[vlps_pkg::FLAG_HEADLIGHT]
                   || (flags_r[vlps_pkg::FLAG_CUSTOM_HI:vlps_pkg::FLAG_CUSTOM_LO] != '0)) begin
        d_hi    = SPAN_C;
        d_color = head_color_r;
      end
    end
  end

  assign q_push = accept && is_tick;
  assign q_data = {d_fault, d_color, d_lo, d_hi};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdog_limit_r    <= vlps_pkg::RST_WDOG_LIMIT;
      head_color_r    <= vlps_pkg::RST_HEAD_COLOR;
      resp_left_r     <= 1'b1;
      resp_right_r    <= 1'b1;
      step_ticks_r    <= vlps_pkg::RST_STEP_TICKS;
      hold_ticks_r    <= vlps_pkg::RST_HOLD_TICKS;
      strobe_period_r <= vlps_pkg::RST_STROBE_PERIOD;
      strobe_on_r     <= vlps_pkg::RST_STROBE_ON;
    end else if (cfg_we) begin
      case (cfg_index)
        vlps_pkg::REG_WDOG_LIMIT:    wdog_limit_r    <= cfg_wdata[vlps_pkg::WDOG_W-1:0];
        vlps_pkg::REG_HEAD_COLOR:    head_color_r    <= cfg_wdata[vlps_pkg::COLOR_W-1:0];
        vlps_pkg::REG_RESP_LEFT:     resp_left_r     <= cfg_wdata[0];
        vlps_pkg::REG_RESP_RIGHT:    resp_right_r    <= cfg_wdata[0];
        vlps_pkg::REG_STEP_TICKS:    step_ticks_r    <= cfg_wdata[TW-1:0];
        vlps_pkg::REG_HOLD_TICKS:    hold_ticks_r    <= cfg_wdata[TW-1:0];
        vlps_pkg::REG_STROBE_PERIOD: strobe_period_r <= cfg_wdata[TW-1:0];
        vlps_pkg::REG_STROBE_ON:     strobe_on_r     <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Command and animation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r       <= '0;
      last_time_r   <= '0;
      turn_phase_r  <= TURN_FILLING;
      turn_fill_r   <= '0;
      turn_empty_r  <= '0;
      turn_tick_r   <= '0;
      brake_phase_r <= BRAKE_IDLE;
      brake_fill_r  <= '0;
      brake_empty_r <= '0;
      brake_tick_r  <= '0;
      strobe_tick_r <= '0;
    end else begin
      flags_r       <= flags_nxt;
      last_time_r   <= last_time_nxt;
      turn_phase_r  <= turn_phase_nxt;
      turn_fill_r   <= turn_fill_nxt;
      turn_empty_r  <= turn_empty_nxt;
      turn_tick_r   <= turn_tick_nxt;
      brake_phase_r <= brake_phase_nxt;
      brake_fill_r  <= brake_fill_nxt;
      brake_empty_r <= brake_empty_nxt;
      brake_tick_r  <= brake_tick_nxt;
      strobe_tick_r <= strobe_tick_nxt;
    end
  end

endmodule

// File: rtl/core/vlps_back.sv
// ----------------------------------------------------------------------------
// vlps_back
// Expands one frame descriptor into one color beat per LED through an
// output register.
// ----------------------------------------------------------------------------
module vlps_back #(
  parameter int NUM_LEDS      = vlps_pkg::NUM_LEDS_DEF,
  parameter int FIRST_LIT_LED = vlps_pkg::FIRST_LIT_LED_DEF,
  parameter int DESC_W        = 1 + vlps_pkg::COLOR_W
                                + 2 * vlps_pkg::cnt_width(NUM_LEDS, FIRST_LIT_LED)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [DESC_W-1:0] q_data,
  output logic              q_pop,
  vlps_out_if.source        out_chan
);

  localparam int CNT_W = vlps_pkg::cnt_width(NUM_LEDS, FIRST_LIT_LED);
  localparam int IDX_W = $clog2(NUM_LEDS);
  localparam int CMP_W = $clog2(NUM_LEDS + FIRST_LIT_LED + 1);

  logic [IDX_W-1:0]               idx_r;
  logic                           out_valid_r;
  logic [vlps_pkg::LED_IDX_W-1:0] led_index_r;
  logic [vlps_pkg::COLOR_W-1:0]   pixel_color_r;
  logic                           fault_r, last_r;

  logic                           d_fault;
  logic [vlps_pkg::COLOR_W-1:0]   d_color;
  logic [CNT_W-1:0]               d_lo, d_hi;
  logic [CMP_W-1:0]               pos, lo_abs, hi_abs;
  logic                           advance, at_last, lit;

  assign {d_fault, d_color, d_lo, d_hi} = q_data;

  // Position test against the lit window
  assign pos     = CMP_W'(idx_r);
  assign lo_abs  = CMP_W'(d_lo) + CMP_W'(FIRST_LIT_LED);
  assign hi_abs  = CMP_W'(d_hi) + CMP_W'(FIRST_LIT_LED);
  assign lit     = (pos >= lo_abs) && (pos < hi_abs);

  assign advance = !q_empty && (!out_valid_r || out_chan.ready);
  assign at_last = (idx_r == IDX_W'(NUM_LEDS - 1));
  assign q_pop   = advance && at_last;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.led_index   = led_index_r;
  assign out_chan.pixel_color = pixel_color_r;
  assign out_chan.fault_code  = fault_r;
  assign out_chan.last_led    = last_r;

  // LED counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= at_last ? '0 : idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      led_index_r   <= vlps_pkg::LED_IDX_W'(idx_r);
      pixel_color_r <= lit ? d_color : vlps_pkg::COLOR_OFF;
      fault_r       <= d_fault;
      last_r        <= at_last;
    end
  end

endmodule

// File: rtl/core/vehicle_light_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// vehicle_light_pattern_sequencer
// Light pattern sequencer for a string of addressable LEDs.
// ----------------------------------------------------------------------------
// A command item (opcode 0) yields no beats; a matching frame latches the
// flag byte and its time. A frame tick (opcode 1) is classified in the cycle
// it is accepted: watchdog check, pattern choice and animation step, and a
// frame descriptor is queued. The back end then emits NUM_LEDS beats, one LED
// per cycle while out_chan.ready stays high, in index order with last_led on
// the final one; that single emitter sets the sustained rate. The first beat
// of a tick passes through the descriptor queue and then the output register.
// A two-entry descriptor queue lets the input side keep accepting while the
// output side stalls; input ready drops only while the queue is full.
module vehicle_light_pattern_sequencer #(
  parameter int NUM_LEDS      = vlps_pkg::NUM_LEDS_DEF,
  parameter int FIRST_LIT_LED = vlps_pkg::FIRST_LIT_LED_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  vlps_in_if.sink                          in_chan,
  vlps_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [vlps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vlps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DESC_W = 1 + vlps_pkg::COLOR_W
                          + 2 * vlps_pkg::cnt_width(NUM_LEDS, FIRST_LIT_LED);

  logic              q_push, q_full, q_pop, q_empty;
  logic [DESC_W-1:0] q_wdata, q_rdata;

  // Front end: accept, classify, animate
  vlps_front #(
    .NUM_LEDS      (NUM_LEDS),
    .FIRST_LIT_LED (FIRST_LIT_LED),
    .DESC_W        (DESC_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Descriptor queue
  vlps_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (vlps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: per-LED emitter
  vlps_back #(
    .NUM_LEDS      (NUM_LEDS),
    .FIRST_LIT_LED (FIRST_LIT_LED),
    .DESC_W        (DESC_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
